### hdl/sst_pkg.sv
`timescale 1ns / 1ps

package sst_pkg;

    localparam int REQ_BITS    = 3;
    localparam int ID_BITS     = 10;
    localparam int STATUS_BITS = 2;
    localparam int SLOT_BITS   = 8;
    localparam int COUNT_BITS  = 9;

    localparam logic [REQ_BITS-1:0] REQ_ADD    = 3'd0;
    localparam logic [REQ_BITS-1:0] REQ_SET    = 3'd1;
    localparam logic [REQ_BITS-1:0] REQ_REMOVE = 3'd2;
    localparam logic [REQ_BITS-1:0] REQ_GET    = 3'd3;
    localparam logic [REQ_BITS-1:0] REQ_HAS    = 3'd4;

    localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_ALREADY   = 2'd3;

endpackage

### hdl/sst_ram.sv
`timescale 1ns / 1ps

module sst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/sparse_set_component_table.sv
`timescale 1ns / 1ps
// path: add, set, has and misses go from input transfer through the map read to the result register,
// get and remove add one dense read between the map read and the result register
// requests are taken one at a time: s_ready stays low until the last result is registered
// reset: synchronous active-low aresetn; a clearing pass then walks every entry of the
// entity map, with s_ready low until it ends
module sparse_set_component_table #(
    parameter int MAX_ENTITIES = 1024,
    parameter int CAPACITY     = 256,
    parameter int DATA_BITS    = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [sst_pkg::REQ_BITS-1:0]       s_req_type,
    input  logic [sst_pkg::ID_BITS-1:0]        s_entity_id,
    input  logic [DATA_BITS-1:0]               s_data_in,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [sst_pkg::STATUS_BITS-1:0]    m_status,
    output logic                               m_present,
    output logic [sst_pkg::SLOT_BITS-1:0]      m_slot,
    output logic [DATA_BITS-1:0]               m_data_out,
    output logic [sst_pkg::COUNT_BITS-1:0]     m_live_count
);

    localparam int EW = $clog2(MAX_ENTITIES);
    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int MAP_W = SW + 1;
    localparam int DENSE_W = EW + DATA_BITS;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_LOOKUP = 6'b000100,
        S_GET_RD = 6'b001000,
        S_REM_RD = 6'b010000,
        S_RESULT = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [sst_pkg::REQ_BITS-1:0] req_reg, req_next;
    logic [sst_pkg::ID_BITS-1:0] id_reg, id_next;
    logic [DATA_BITS-1:0] data_reg, data_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [CW-1:0] count_reg, count_next;
    logic [EW-1:0] clr_reg, clr_next;

    logic [sst_pkg::STATUS_BITS-1:0] res_status_reg, res_status_next;
    logic res_present_reg, res_present_next;
    logic [SW-1:0] res_slot_reg, res_slot_next;
    logic [DATA_BITS-1:0] res_data_reg, res_data_next;

    logic m_valid_reg, m_valid_next;
    logic [sst_pkg::STATUS_BITS-1:0] m_status_reg, m_status_next;
    logic m_present_reg, m_present_next;
    logic [sst_pkg::SLOT_BITS-1:0] m_slot_reg, m_slot_next;
    logic [DATA_BITS-1:0] m_data_reg, m_data_next;
    logic [sst_pkg::COUNT_BITS-1:0] m_count_reg, m_count_next;

    logic map_we;
    logic [EW-1:0] map_waddr, map_raddr;
    logic [MAP_W-1:0] map_wdata, map_rdata;
    logic dense_we;
    logic [SW-1:0] dense_waddr, dense_raddr;
    logic [DENSE_W-1:0] dense_wdata, dense_rdata;

    logic [EW-1:0] id_idx;
    logic in_range, here, full, out_free;
    logic [SW-1:0] map_slot, last_slot;
    logic [EW-1:0] mover;

    // sparse map: {valid, slot} per entity
    sst_ram #(.WIDTH(MAP_W), .DEPTH(MAX_ENTITIES)) u_map (
        .aclk  (aclk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    // dense list: {owner, data} per slot
    sst_ram #(.WIDTH(DENSE_W), .DEPTH(CAPACITY)) u_dense (
        .aclk  (aclk),
        .we    (dense_we),
        .waddr (dense_waddr),
        .wdata (dense_wdata),
        .raddr (dense_raddr),
        .rdata (dense_rdata)
    );

    assign id_idx    = EW'(id_reg);
    assign in_range  = 32'(id_reg) < 32'(MAX_ENTITIES);
    assign here      = in_range && map_rdata[SW];
    assign map_slot  = map_rdata[SW-1:0];
    assign full      = count_reg == CW'(CAPACITY);
    assign last_slot = SW'(count_reg - CW'(1));
    assign mover     = dense_rdata[DENSE_W-1:DATA_BITS];
    assign out_free  = !m_valid_reg || m_ready;

    assign s_ready      = state_reg == S_IDLE;
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_present    = m_present_reg;
    assign m_slot       = m_slot_reg;
    assign m_data_out   = m_data_reg;
    assign m_live_count = m_count_reg;

    always_comb begin
        state_next       = state_reg;
        req_next         = req_reg;
        id_next          = id_reg;
        data_next        = data_reg;
        slot_next        = slot_reg;
        count_next       = count_reg;
        clr_next         = clr_reg;
        res_status_next  = res_status_reg;
        res_present_next = res_present_reg;
        res_slot_next    = res_slot_reg;
        res_data_next    = res_data_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_status_next    = m_status_reg;
        m_present_next   = m_present_reg;
        m_slot_next      = m_slot_reg;
        m_data_next      = m_data_reg;
        m_count_next     = m_count_reg;

        map_we      = 1'b0;
        map_waddr   = id_idx;
        map_wdata   = '0;
        map_raddr   = EW'(s_entity_id);
        dense_we    = 1'b0;
        dense_waddr = slot_reg;
        dense_wdata = {id_idx, data_reg};
        dense_raddr = map_slot;

        case (state_reg)
            S_CLEAR: begin
                map_we    = 1'b1;
                map_waddr = clr_reg;
                clr_next  = clr_reg + EW'(1);
                if (clr_reg == EW'(MAX_ENTITIES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    req_next   = s_req_type;
                    id_next    = s_entity_id;
                    data_next  = s_data_in;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                res_status_next  = sst_pkg::ST_OK;
                res_present_next = here;
                res_slot_next    = '0;
                res_data_next    = '0;
                state_next       = S_RESULT;
                case (req_reg)
                    sst_pkg::REQ_ADD: begin
                        if (!in_range) begin
                            res_status_next = sst_pkg::ST_NOT_FOUND;
                        end else if (here) begin
                            res_status_next = sst_pkg::ST_ALREADY;
                        end else if (full) begin
                            res_status_next = sst_pkg::ST_FULL;
                        end else begin
                            dense_we         = 1'b1;
                            dense_waddr      = SW'(count_reg);
                            map_we           = 1'b1;
                            map_wdata        = {1'b1, SW'(count_reg)};
                            count_next       = count_reg + CW'(1);
                            res_present_next = 1'b1;
                            res_slot_next    = SW'(count_reg);
                        end
                    end
                    sst_pkg::REQ_SET: begin
                        if (!here) begin
                            res_status_next = sst_pkg::ST_NOT_FOUND;
                        end else begin
                            // owner of this slot is the entity itself
                            dense_we      = 1'b1;
                            dense_waddr   = map_slot;
                            res_slot_next = map_slot;
                        end
                    end
                    sst_pkg::REQ_REMOVE: begin
                        if (!here) begin
                            res_status_next = sst_pkg::ST_NOT_FOUND;
                        end else begin
                            // drop the entity now, the mover is patched next cycle
                            map_we           = 1'b1;
                            slot_next        = map_slot;
                            dense_raddr      = last_slot;
                            res_present_next = 1'b0;
                            state_next       = S_REM_RD;
                        end
                    end
                    sst_pkg::REQ_GET: begin
                        if (!here) begin
                            res_status_next = sst_pkg::ST_NOT_FOUND;
                        end else begin
                            res_slot_next = map_slot;
                            state_next    = S_GET_RD;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_GET_RD: begin
                res_data_next = dense_rdata[DATA_BITS-1:0];
                state_next    = S_RESULT;
            end
            S_REM_RD: begin
                // swap the last slot into the hole unless the hole is the last slot
                if (slot_reg != last_slot) begin
                    dense_we    = 1'b1;
                    dense_waddr = slot_reg;
                    dense_wdata = dense_rdata;
                    map_we      = 1'b1;
                    map_waddr   = mover;
                    map_wdata   = {1'b1, slot_reg};
                end
                count_next = count_reg - CW'(1);
                state_next = S_RESULT;
            end
            S_RESULT: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_status_next  = res_status_reg;
                    m_present_next = res_present_reg;
                    m_slot_next    = sst_pkg::SLOT_BITS'(res_slot_reg);
                    m_data_next    = res_data_reg;
                    m_count_next   = sst_pkg::COUNT_BITS'(count_reg);
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            count_reg   <= '0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
        req_reg         <= req_next;
        id_reg          <= id_next;
        data_reg        <= data_next;
        slot_reg        <= slot_next;
        res_status_reg  <= res_status_next;
        res_present_reg <= res_present_next;
        res_slot_reg    <= res_slot_next;
        res_data_reg    <= res_data_next;
        m_status_reg    <= m_status_next;
        m_present_reg   <= m_present_next;
        m_slot_reg      <= m_slot_next;
        m_data_reg      <= m_data_next;
        m_count_reg     <= m_count_next;
    end

endmodule

### tb/sv/sst_table_checker.sv
`timescale 1ns / 1ps

module sst_table_checker #(
    parameter int MAX_ENTITIES = 1024,
    parameter int CAPACITY     = 256,
    parameter int DATA_BITS    = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic [sst_pkg::REQ_BITS-1:0]       s_req_type,
    input  logic [sst_pkg::ID_BITS-1:0]        s_entity_id,
    input  logic [DATA_BITS-1:0]               s_data_in,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic [sst_pkg::STATUS_BITS-1:0]    m_status,
    input  logic                               m_present,
    input  logic [sst_pkg::SLOT_BITS-1:0]      m_slot,
    input  logic [DATA_BITS-1:0]               m_data_out,
    input  logic [sst_pkg::COUNT_BITS-1:0]     m_live_count,
    output int                                 mismatches,
    output int                                 pending
);

    typedef struct packed {
        logic [sst_pkg::STATUS_BITS-1:0] status;
        logic                            present;
        logic [sst_pkg::SLOT_BITS-1:0]   slot;
        logic [DATA_BITS-1:0]            word;
        logic [sst_pkg::COUNT_BITS-1:0]  count;
    } table_reply_t;

    // shadow copy of the sparse map and the dense store
    logic                            ent_live  [MAX_ENTITIES];
    logic [sst_pkg::SLOT_BITS-1:0]   ent_slot  [MAX_ENTITIES];
    logic [sst_pkg::ID_BITS-1:0]     slot_ent  [CAPACITY];
    logic [DATA_BITS-1:0]            slot_word [CAPACITY];
    logic [sst_pkg::COUNT_BITS-1:0]  live_cnt;

    table_reply_t expected_replies[$];

    function automatic table_reply_t apply_request(
        input logic [sst_pkg::REQ_BITS-1:0] kind,
        input logic [sst_pkg::ID_BITS-1:0]  id,
        input logic [DATA_BITS-1:0]         word
    );
        table_reply_t                r;
        logic                        hit;
        int                          s;
        int                          last;
        logic [sst_pkg::ID_BITS-1:0] mover;
        r = '0;
        r.status = sst_pkg::ST_OK;
        hit = (id < MAX_ENTITIES) && ent_live[id];
        case (kind)
            sst_pkg::REQ_ADD: begin
                if (id >= MAX_ENTITIES) begin
                    r.status = sst_pkg::ST_NOT_FOUND;
                end else if (hit) begin
                    r.status = sst_pkg::ST_ALREADY;
                end else if (live_cnt >= CAPACITY) begin
                    r.status = sst_pkg::ST_FULL;
                end else begin
                    s = int'(live_cnt);
                    slot_word[s] = word;
                    slot_ent[s]  = id;
                    ent_slot[id] = s[sst_pkg::SLOT_BITS-1:0];
                    ent_live[id] = 1'b1;
                    live_cnt     = live_cnt + 1'b1;
                    r.slot       = s[sst_pkg::SLOT_BITS-1:0];
                end
            end
            sst_pkg::REQ_SET: begin
                if (!hit) begin
                    r.status = sst_pkg::ST_NOT_FOUND;
                end else begin
                    s = int'(ent_slot[id]);
                    slot_word[s] = word;
                    r.slot = s[sst_pkg::SLOT_BITS-1:0];
                end
            end
            sst_pkg::REQ_REMOVE: begin
                if (!hit || live_cnt == 0) begin
                    r.status = sst_pkg::ST_NOT_FOUND;
                end else begin
                    s    = int'(ent_slot[id]);
                    last = int'(live_cnt) - 1;
                    // swap the last slot into the hole
                    if (s != last) begin
                        mover           = slot_ent[last];
                        slot_word[s]    = slot_word[last];
                        slot_ent[s]     = mover;
                        ent_slot[mover] = s[sst_pkg::SLOT_BITS-1:0];
                    end
                    ent_live[id] = 1'b0;
                    live_cnt     = last[sst_pkg::COUNT_BITS-1:0];
                end
            end
            sst_pkg::REQ_GET: begin
                if (!hit) begin
                    r.status = sst_pkg::ST_NOT_FOUND;
                end else begin
                    s = int'(ent_slot[id]);
                    r.word = slot_word[s];
                    r.slot = s[sst_pkg::SLOT_BITS-1:0];
                end
            end
            default: ;
        endcase
        r.present = (id < MAX_ENTITIES) && ent_live[id];
        r.count   = live_cnt;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch on %s: got %0h, expected %0h", $time, field, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        table_reply_t want;
        if (!aresetn) begin
            for (int i = 0; i < MAX_ENTITIES; i++)
                ent_live[i] = 1'b0;
            live_cnt = '0;
            expected_replies.delete();
            mismatches = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_replies.size() == 0) begin
                    report_mismatch("result with no request waiting", m_status, '0);
                end else begin
                    want = expected_replies.pop_front();
                    if (m_status !== want.status)
                        report_mismatch("status", m_status, want.status);
                    if (m_present !== want.present)
                        report_mismatch("present", m_present, want.present);
                    if (m_slot !== want.slot)
                        report_mismatch("slot", m_slot, want.slot);
                    if (m_data_out !== want.word)
                        report_mismatch("data_out", m_data_out, want.word);
                    if (m_live_count !== want.count)
                        report_mismatch("live_count", m_live_count, want.count);
                end
            end
            if (s_valid && s_ready)
                expected_replies.insert(expected_replies.size(),
                                        apply_request(s_req_type, s_entity_id, s_data_in));
        end
        pending <= expected_replies.size();
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_ENTITIES = 1024;
    localparam int CAPACITY     = 256;
    localparam int DATA_BITS    = 64;

    // request codes the block leaves unused
    localparam logic [sst_pkg::REQ_BITS-1:0] REQ_SPARE_LO = 3'd5;
    localparam logic [sst_pkg::REQ_BITS-1:0] REQ_SPARE_HI = 3'd7;

    localparam logic [sst_pkg::ID_BITS-1:0] ID_TOP    = '1;
    localparam int                          FILL_SPAN = 512;
    localparam int                          FILL_LEN  = 270;

    // receiver stall patterns
    localparam int READY_ALWAYS = 0;
    localparam int READY_COIN   = 1;
    localparam int READY_SPARSE = 2;
    localparam int READY_EVERY4 = 3;

    logic                               aclk = 1'b0;
    logic                               aresetn = 1'b0;
    logic                               s_valid = 1'b0;
    logic                               s_ready;
    logic [sst_pkg::REQ_BITS-1:0]       s_req_type = '0;
    logic [sst_pkg::ID_BITS-1:0]        s_entity_id = '0;
    logic [DATA_BITS-1:0]               s_data_in = '0;
    logic                               m_valid;
    logic                               m_ready = 1'b0;
    logic [sst_pkg::STATUS_BITS-1:0]    m_status;
    logic                               m_present;
    logic [sst_pkg::SLOT_BITS-1:0]      m_slot;
    logic [DATA_BITS-1:0]               m_data_out;
    logic [sst_pkg::COUNT_BITS-1:0]     m_live_count;

    int mismatches;
    int pending;
    int burst_left = 0;
    int fill_base;
    int fill_step;
    int ready_mode = READY_ALWAYS;
    int ready_left = 0;

    sparse_set_component_table #(
        .MAX_ENTITIES(MAX_ENTITIES),
        .CAPACITY(CAPACITY),
        .DATA_BITS(DATA_BITS)
    ) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_req_type(s_req_type), .s_entity_id(s_entity_id), .s_data_in(s_data_in),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_status(m_status), .m_present(m_present), .m_slot(m_slot),
        .m_data_out(m_data_out), .m_live_count(m_live_count)
    );

    sst_table_checker #(
        .MAX_ENTITIES(MAX_ENTITIES),
        .CAPACITY(CAPACITY),
        .DATA_BITS(DATA_BITS)
    ) table_check (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_req_type(s_req_type), .s_entity_id(s_entity_id), .s_data_in(s_data_in),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_status(m_status), .m_present(m_present), .m_slot(m_slot),
        .m_data_out(m_data_out), .m_live_count(m_live_count),
        .mismatches(mismatches), .pending(pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (ready_left == 0) begin
                ready_mode = $urandom_range(READY_ALWAYS, READY_EVERY4);
                ready_left = $urandom_range(20, 150);
            end
            ready_left--;
            case (ready_mode)
                READY_ALWAYS: m_ready <= 1'b1;
                READY_COIN:   m_ready <= 1'($urandom_range(0, 1));
                READY_SPARSE: m_ready <= ($urandom_range(0, 7) == 0);
                default:      m_ready <= (ready_left % 4 == 0);
            endcase
        end
    end

    function automatic logic [DATA_BITS-1:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return '1;
            1:       return '0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // mostly a small pool so requests keep hitting live entities
    function automatic logic [sst_pkg::ID_BITS-1:0] scattered_id();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 8)
            return sst_pkg::ID_BITS'($urandom_range(0, 47));
        else if (pick == 8)
            return $urandom_range(0, 1) ? ID_TOP : '0;
        else
            return sst_pkg::ID_BITS'($urandom_range(0, MAX_ENTITIES - 1));
    endfunction

    // distinct ids in the upper half for the fill sequence
    function automatic logic [sst_pkg::ID_BITS-1:0] fill_id(input int k);
        return sst_pkg::ID_BITS'(FILL_SPAN + ((fill_base + k * fill_step) % FILL_SPAN));
    endfunction

    function automatic logic [sst_pkg::REQ_BITS-1:0] random_kind();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)      return sst_pkg::REQ_ADD;
        else if (pick < 45) return sst_pkg::REQ_SET;
        else if (pick < 65) return sst_pkg::REQ_REMOVE;
        else if (pick < 80) return sst_pkg::REQ_GET;
        else if (pick < 92) return sst_pkg::REQ_HAS;
        else return sst_pkg::REQ_BITS'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
    endfunction

    task automatic send_req(input logic [sst_pkg::REQ_BITS-1:0] kind,
                            input logic [sst_pkg::ID_BITS-1:0] id,
                            input logic [DATA_BITS-1:0] word);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
        s_valid     <= 1'b1;
        s_req_type  <= kind;
        s_entity_id <= id;
        s_data_in   <= word;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
    endtask

    // hold off the sender until every result is back
    task automatic wait_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin : stimulus
        int k;
        int pick;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: misses on an empty table, extremes, spare codes, swap on remove
        send_req(sst_pkg::REQ_GET, '0, '0);
        send_req(sst_pkg::REQ_SET, '0, 64'hAAAA_AAAA_AAAA_AAAA);
        send_req(sst_pkg::REQ_REMOVE, '0, '0);
        send_req(sst_pkg::REQ_HAS, '0, '0);
        send_req(sst_pkg::REQ_ADD, '0, '1);
        send_req(sst_pkg::REQ_ADD, ID_TOP, '0);
        send_req(sst_pkg::REQ_ADD, '0, 64'h0123_4567_89AB_CDEF);
        send_req(sst_pkg::REQ_GET, '0, '0);
        send_req(sst_pkg::REQ_GET, ID_TOP, '0);
        send_req(sst_pkg::REQ_HAS, ID_TOP, '0);
        send_req(sst_pkg::REQ_SET, ID_TOP, 64'h5555_5555_5555_5555);
        send_req(sst_pkg::REQ_GET, ID_TOP, '1);
        for (k = REQ_SPARE_LO; k <= REQ_SPARE_HI; k++)
            send_req(sst_pkg::REQ_BITS'(k), '0, '1);
        send_req(sst_pkg::REQ_ADD, 10'd5, 64'hFEED_0000_0000_0005);
        send_req(sst_pkg::REQ_ADD, 10'd6, 64'hFEED_0000_0000_0006);
        send_req(sst_pkg::REQ_REMOVE, '0, '0);
        send_req(sst_pkg::REQ_GET, 10'd6, '0);
        send_req(sst_pkg::REQ_REMOVE, 10'd5, '0);
        send_req(sst_pkg::REQ_GET, 10'd6, '0);
        send_req(sst_pkg::REQ_GET, ID_TOP, '0);
        send_req(sst_pkg::REQ_REMOVE, 10'd6, '0);
        send_req(sst_pkg::REQ_HAS, 10'd6, '0);

        for (k = 0; k < 60; k++)
            send_req(random_kind(), scattered_id(), rand_word());
        wait_drain();

        // fill past capacity so the full answer shows up
        fill_base = $urandom_range(0, FILL_SPAN - 1);
        fill_step = 2 * $urandom_range(0, FILL_SPAN / 2 - 1) + 1;
        for (k = 0; k < FILL_LEN; k++) begin
            if ($urandom_range(0, 4) == 0)
                send_req(random_kind(), fill_id($urandom_range(0, k)), rand_word());
            send_req(sst_pkg::REQ_ADD, fill_id(k), rand_word());
        end
        wait_drain();

        // drain with removes from all over the dense list
        for (k = 0; k < 90; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                send_req(sst_pkg::REQ_REMOVE, fill_id($urandom_range(0, FILL_LEN - 1)),
                         rand_word());
            else if (pick < 80)
                send_req(sst_pkg::REQ_GET, fill_id($urandom_range(0, FILL_LEN - 1)),
                         rand_word());
            else
                send_req(random_kind(), scattered_id(), rand_word());
        end
        wait_drain();
        repeat (20) @(posedge aclk);

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
